// ----- design/calendar_date_add_days_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Calendar date adder assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADD_DAYS_UNIT_MACROS_SVH
`define CALENDAR_DATE_ADD_DAYS_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define CDAD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define CDAD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define CDAD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CDAD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- design/cdad_pkg.sv -----
// ----------------------------------------------------------------------------
// cdad_pkg
// Types, constants and month table shared by the date adder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdad_pkg;

	localparam int unsigned DAY_COUNT_BITS_DEF = 16;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;

	// month codes
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
	localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
	localparam logic [DAY_W-1:0] LEN_FEB_L = 5'd29;
	localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

	// year / 100 by reciprocal: (y * 5243) >> 19, exact for y < 2^14
	localparam int unsigned DIV100_MUL_W = 13;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned PROD_W       = YEAR_W + DIV100_MUL_W;
	localparam int unsigned Q100_W       = PROD_W - DIV100_SHIFT;
	localparam int unsigned R100_W       = 7;
	localparam logic [R100_W-1:0] CENTURY      = 7'd100;
	localparam logic [R100_W-1:0] CENTURY_LAST = 7'd99;
	localparam logic [YEAR_W-1:0] YEAR_MAX     = 14'h3FFF;

	typedef struct packed {
		logic load;  // capture a new beat
		logic prep;  // year / 100
		logic init;  // year % 100, century % 4
		logic step;  // one month per cycle
	} cdad_cmd_t;

	typedef struct packed {
		logic fits;  // remaining days fit in current month
	} cdad_sts_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
	                                               input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
			MONTH_FEB: len = leap ? LEN_FEB_L : LEN_FEB;
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- design/cdad_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdad_ctrl
// Sequencer: capture, leap-rule setup, then one month step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_add_days_unit_macros.svh"

module cdad_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire cdad_pkg::cdad_sts_t sts,
	output cdad_pkg::cdad_cmd_t      cmd,
	output logic                     busy
);
	import cdad_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_INIT = 4'b0100,
		S_STEP = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (sts.fits) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`CDAD_ASSERT_NXT(a_start_prep, clk, arst_n, (state_q == S_IDLE) && start, state_q == S_PREP)
	`CDAD_ASSERT_NXT(a_step_hold, clk, arst_n, (state_q == S_STEP) && !sts.fits, state_q == S_STEP)
	`CDAD_ASSERT_IMP(a_busy_rise, clk, arst_n, $rose(busy), $past(start))

endmodule

`default_nettype wire

// ----- design/cdad_dp.sv -----
// ----------------------------------------------------------------------------
// cdad_dp
// Date registers, leap residues, month step and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "calendar_date_add_days_unit_macros.svh"

module cdad_dp #(
	parameter int unsigned DAY_COUNT_BITS = cdad_pkg::DAY_COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdad_pkg::cdad_cmd_t           cmd,
	output cdad_pkg::cdad_sts_t                sts,
	input  wire logic [cdad_pkg::DAY_W-1:0]    start_day,
	input  wire logic [cdad_pkg::MONTH_W-1:0]  start_month,
	input  wire logic [cdad_pkg::YEAR_W-1:0]   start_year,
	input  wire logic [DAY_COUNT_BITS-1:0]     days_to_add,
	output logic      [cdad_pkg::DAY_W-1:0]    end_day,
	output logic      [cdad_pkg::MONTH_W-1:0]  end_month,
	output logic      [cdad_pkg::YEAR_W-1:0]   end_year,
	output logic                               done
);
	import cdad_pkg::*;

	localparam int unsigned REM_W = DAY_COUNT_BITS + 1;

	logic [REM_W-1:0]   rem_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [Q100_W-1:0]  q100_q;
	logic [R100_W-1:0]  r100_q;
	logic [1:0]         c400_q;
	logic [DAY_W-1:0]   end_day_q;
	logic [MONTH_W-1:0] end_month_q;
	logic [YEAR_W-1:0]  end_year_q;
	logic               done_q;

	logic [PROD_W-1:0]  prod_100;
	logic [YEAR_W-1:0]  r100_full;
	logic               leap;
	logic [DAY_W-1:0]   len;
	logic               fits;
	logic               month_bad;

	assign prod_100  = PROD_W'(year_q) * PROD_W'(DIV100_MUL);
	assign r100_full = year_q - (YEAR_W'(q100_q) * YEAR_W'(CENTURY));

	// divisible by 400, or by 4 and not by 100
	assign leap = (r100_q == '0) ? (c400_q == 2'd0) : (year_q[1:0] == 2'd0);
	assign len  = month_len(month_q, leap);
	assign fits = (rem_q <= REM_W'(len));
	assign sts.fits = fits;

	assign month_bad = (start_month < MONTH_JAN) || (start_month > MONTH_DEC);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q   <= REM_W'(start_day) + REM_W'(days_to_add);
			month_q <= month_bad ? MONTH_JAN : start_month;
			year_q  <= start_year;
		end
		if (cmd.prep) begin
			q100_q <= prod_100[DIV100_SHIFT +: Q100_W];
		end
		if (cmd.init) begin
			r100_q <= r100_full[R100_W-1:0];
			c400_q <= q100_q[1:0];
		end
		if (cmd.step) begin
			if (fits) begin
				end_day_q   <= (rem_q == '0) ? DAY_W'(1) : rem_q[DAY_W-1:0];
				end_month_q <= month_q;
				end_year_q  <= year_q;
			end else begin
				rem_q <= rem_q - REM_W'(len);
				if (month_q == MONTH_DEC) begin
					month_q <= MONTH_JAN;
					year_q  <= year_q + YEAR_W'(1);
					// year wraps to 0: both residues restart at 0
					if (year_q == YEAR_MAX) begin
						r100_q <= '0;
						c400_q <= 2'd0;
					end else if (r100_q == CENTURY_LAST) begin
						r100_q <= '0;
						c400_q <= c400_q + 2'd1;
					end else begin
						r100_q <= r100_q + R100_W'(1);
					end
				end else begin
					month_q <= month_q + MONTH_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.step && fits;
		end
	end

	assign end_day   = end_day_q;
	assign end_month = end_month_q;
	assign end_year  = end_year_q;
	assign done      = done_q;

	`CDAD_ASSERT_IMP(a_day_nonzero, clk, arst_n, done_q, end_day_q != '0)
	`CDAD_ASSERT_IMP(a_month_range, clk, arst_n, done_q, (end_month_q >= MONTH_JAN) && (end_month_q <= MONTH_DEC))
	`CDAD_ASSERT_IMP(a_r100_range, clk, arst_n, cmd.step, r100_q < CENTURY)

endmodule

`default_nettype wire

// ----- design/calendar_date_add_days_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit
// Gregorian date plus day count, stepped one month per clock.
// ----------------------------------------------------------------------------
//
// channel  | ports                                      | handshake
// ---------+--------------------------------------------+------------------------
// request  | start_day start_month start_year days_to_add | start && !busy
// result   | end_day end_month end_year                 | done, one-cycle strobe
//
// Sequence: after the edge that takes a beat, prep and init run, then each step
//   subtracts one month length until the remainder fits; done is registered
//   from that final step of the month step loop in cdad_dp.
// Setup: the prep and init states before stepping compute year / 100 (reciprocal multiply)
//   and year % 100, century % 4, which carry the leap rule across year steps.
// Reset: arst_n clears the sequencer and the strobe; date registers hold junk.
// Stalls: the receiver cannot stall; results sit on the ports until the next
//   beat completes, and busy stays high from accept until the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_add_days_unit #(
	parameter int unsigned DAY_COUNT_BITS = cdad_pkg::DAY_COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [cdad_pkg::DAY_W-1:0]    start_day,
	input  wire logic [cdad_pkg::MONTH_W-1:0]  start_month,
	input  wire logic [cdad_pkg::YEAR_W-1:0]   start_year,
	input  wire logic [DAY_COUNT_BITS-1:0]     days_to_add,
	output logic                               done,
	output logic      [cdad_pkg::DAY_W-1:0]    end_day,
	output logic      [cdad_pkg::MONTH_W-1:0]  end_month,
	output logic      [cdad_pkg::YEAR_W-1:0]   end_year
);
	import cdad_pkg::*;

	cdad_cmd_t cmd;  // sequencer -> datapath
	cdad_sts_t sts;  // datapath -> sequencer

	// sequencer: idle / prep / init / step
	cdad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: captures the beat on load, strobes done on the final step
	cdad_dp #(
		.DAY_COUNT_BITS (DAY_COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.start_day   (start_day),
		.start_month (start_month),
		.start_year  (start_year),
		.days_to_add (days_to_add),
		.end_day     (end_day),
		.end_month   (end_month),
		.end_year    (end_year),
		.done        (done)
	);

endmodule

`default_nettype wire
